[rtl/psms_pkg.sv]
// shared constants and types for the packed symmetric matrix store
`timescale 1ns / 1ps

package psms_pkg;

    localparam int MAX_DIM_DEF  = 64;
    localparam int CAPACITY_DEF = 2048;

    localparam int MAX_DIM  = MAX_DIM_DEF;
    localparam int DIM_W    = 7;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int K_W      = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIAG     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DECIDE,
        S_FULL_WAIT,
        S_SRCH,
        S_SRCH_CMP,
        S_RESP
    } state_t;

endpackage

[rtl/psms_index.sv]
// packed triangular linear index of a (row, col) pair
`timescale 1ns / 1ps

module psms_index
    import psms_pkg::*;
(
    input  logic [POS_W-1:0] row,
    input  logic [POS_W-1:0] col,
    input  logic [DIM_W-1:0] n,
    input  logic             lower,
    output logic [K_W-1:0]   k
);

    logic [POS_W-1:0]       a;
    logic [POS_W-1:0]       b;
    logic [DIM_W:0]         t_up;
    logic [POS_W+DIM_W:0]   prod_up;
    logic [2*POS_W-1:0]     prod_lo;
    logic [K_W-1:0]         k_up;
    logic [K_W-1:0]         k_lo;

    // swap into the stored triangle
    always_comb
    begin
        if (lower ? (row < col) : (row > col))
        begin
            a = col;
            b = row;
        end
        else
        begin
            a = row;
            b = col;
        end
    end

    // upper: a*(2n - a - 3)/2 - 1 + b
    assign t_up    = {n, 1'b0} - (DIM_W+1)'(a) - (DIM_W+1)'(3);
    assign prod_up = (POS_W+DIM_W+1)'(a) * (POS_W+DIM_W+1)'(t_up);
    assign k_up    = K_W'(prod_up[POS_W+DIM_W:1]) + K_W'(b) - K_W'(1);

    // lower: a*(a - 1)/2 + b
    assign prod_lo = (2*POS_W)'(a) * (2*POS_W)'(a - POS_W'(1));
    assign k_lo    = K_W'(prod_lo[2*POS_W-1:1]) + K_W'(b);

    assign k = lower ? k_lo : k_up;

endmodule

[rtl/packed_symmetric_matrix_store.sv]
// top level: packed symmetric matrix store with full and sparse storage
//
// channel  direction  handshake            payload
// in       receive    in_valid / in_stall  action, row, col, value
// out      send       out_valid/ out_stall read_value, status
// cfg      receive    cfg_valid/ cfg_ready cfg_index, cfg_data
//
// one item at a time; errors and sets pass from accept through S_CALC and S_DECIDE to
// S_RESP, full-mode gets add S_FULL_WAIT, sparse gets add one S_SRCH and S_SRCH_CMP
// per binary search level over the index memory (one read and one compare a level)
// and one more S_SRCH on a miss; 64 rows give at most 2016 indices, so at most 11 levels.
// rst_n resets the state, out_valid and configuration registers, entry count and last index;
// memories and payload registers are not cleared. a new item is taken while the last result still waits on out_stall.
`timescale 1ns / 1ps

module packed_symmetric_matrix_store
    import psms_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [POS_W-1:0]     row,
    input  logic [POS_W-1:0]     col,
    input  logic [VALUE_W-1:0]   value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [VALUE_W-1:0]   read_value,
    output logic [STATUS_W-1:0]  status,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW:0] CAP_C = (AW+1)'(CAPACITY);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]    dim_reg;
    logic                sparse_reg;
    logic                lower_reg;

    logic                act_reg;
    logic [POS_W-1:0]    row_reg;
    logic [POS_W-1:0]    col_reg;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [K_W-1:0]      k_reg;
    logic [STATUS_W-1:0] pre_reg, pre_next;

    logic [AW:0]         count_reg, count_next;
    logic [K_W-1:0]      last_reg, last_next;
    logic [AW:0]         lo_reg, lo_next;
    logic [AW:0]         hi_reg, hi_next;
    logic [AW:0]         mid_reg, mid_next;
    logic [VALUE_W-1:0]  res_val_reg, res_val_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;

    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  read_value_reg, read_value_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [VALUE_W-1:0]  value_mem [CAPACITY];
    logic [K_W-1:0]      index_mem [CAPACITY];
    logic [VALUE_W-1:0]  value_rd_reg;
    logic [K_W-1:0]      index_rd_reg;
    logic                mem_we;
    logic                idx_we;
    logic [AW-1:0]       mem_addr;
    logic [VALUE_W-1:0]  mem_wdata;

    logic [DIM_W-1:0]    n;
    logic [K_W-1:0]      k_calc;
    logic [31:0]         k_ext;
    logic [AW:0]         mid_calc;
    logic                in_accept;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    assign n        = (32'(dim_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_reg;
    assign k_ext    = 32'(k_reg);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    psms_index u_index
    (
        .row   (row_reg),
        .col   (col_reg),
        .n     (n),
        .lower (lower_reg),
        .k     (k_calc)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg    <= DIM_RESET;
            sparse_reg <= 1'b0;
            lower_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIM:    dim_reg    <= cfg_data;
                CFG_SPARSE: sparse_reg <= cfg_data[0];
                CFG_LOWER:  lower_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CALC;
            end
            S_CALC:
                state_next = S_DECIDE;
            S_DECIDE:
            begin
                if (pre_reg == ST_OK && !act_reg)
                    state_next = sparse_reg ? S_SRCH :
                                 ((k_ext >= 32'(CAPACITY)) ? S_RESP : S_FULL_WAIT);
                else
                    state_next = S_RESP;
            end
            S_FULL_WAIT:
                state_next = S_RESP;
            S_SRCH:
                state_next = (lo_reg < hi_reg) ? S_SRCH_CMP : S_RESP;
            S_SRCH_CMP:
                state_next = (k_reg == index_rd_reg) ? S_RESP : S_SRCH;
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        val_next        = val_reg;
        pre_next        = pre_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        res_val_next    = res_val_reg;
        res_st_next     = res_st_reg;
        out_valid_next  = out_valid_reg && out_stall;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        mem_we          = 1'b0;
        idx_we          = 1'b0;
        mem_addr        = k_ext[AW-1:0];
        mem_wdata       = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    val_next = value;
            end
            S_CALC:
            begin
                if ((DIM_W'(row_reg) >= n) || (DIM_W'(col_reg) >= n))
                    pre_next = ST_RANGE;
                else if (row_reg == col_reg)
                    pre_next = ST_DIAG;
                else
                    pre_next = ST_OK;
            end
            S_DECIDE:
            begin
                res_val_next = '0;
                res_st_next  = pre_reg;
                if (pre_reg == ST_OK)
                begin
                    if (!sparse_reg)
                    begin
                        if (k_ext >= 32'(CAPACITY))
                            res_st_next = ST_RANGE;
                        else if (act_reg)
                        begin
                            mem_we       = 1'b1;
                            res_val_next = val_reg;
                        end
                    end
                    else if (act_reg)
                    begin
                        mem_addr = count_reg[AW-1:0];
                        if (count_reg >= CAP_C)
                            res_st_next = ST_FULL;
                        else if (count_reg != '0 && k_reg <= last_reg)
                            res_st_next = ST_ORDER;
                        else
                        begin
                            mem_we       = 1'b1;
                            idx_we       = 1'b1;
                            count_next   = count_reg + (AW+1)'(1);
                            last_next    = k_reg;
                            res_val_next = val_reg;
                        end
                    end
                    else
                    begin
                        lo_next = '0;
                        hi_next = count_reg;
                    end
                end
            end
            S_FULL_WAIT:
                res_val_next = value_rd_reg;
            S_SRCH:
            begin
                mid_next = mid_calc;
                mem_addr = mid_calc[AW-1:0];
                if (lo_reg >= hi_reg)
                    res_st_next = ST_NOTFOUND;
            end
            S_SRCH_CMP:
            begin
                if (k_reg > index_rd_reg)
                    lo_next = mid_reg + (AW+1)'(1);
                else if (k_reg < index_rd_reg)
                    hi_next = mid_reg;
                else
                    res_val_next = value_rd_reg;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = res_val_reg;
                    status_next     = res_st_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload and search registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg <= action;
            row_reg <= row;
            col_reg <= col;
        end
        if (state_reg == S_CALC)
            k_reg <= k_calc;
        val_reg        <= val_next;
        pre_reg        <= pre_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        res_val_reg    <= res_val_next;
        res_st_reg     <= res_st_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    // value and index memories, one address a cycle, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            value_mem[mem_addr] <= mem_wdata;
        if (idx_we)
            index_mem[mem_addr] <= k_reg;
        value_rd_reg <= value_mem[mem_addr];
        index_rd_reg <= index_mem[mem_addr];
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == '0)
        else $error("error result carries a nonzero value");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_srch_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH_CMP |-> mid_reg < hi_reg && mid_reg >= lo_reg)
        else $error("search probe outside its bounds");

    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_CALC)
        else $error("accepted item not taken into index calculation");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(idx_we) && sparse_reg)
        else $error("entry count moved without a sparse append");

endmodule
